FILE: design/kcpm_pkg.sv
// shared types and constants of the key chord prefix match table
// no dependencies
package kcpm_pkg;

	localparam int CODE_W    = 29;
	localparam int MODS_W    = 31;
	localparam int IN_PAIRS  = 4;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 3;
	localparam int PAY_OUT_W = 16;
	localparam int COUNT_W   = 5;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PARTIAL  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EQUAL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

	// scan token handed from cell to cell
	typedef struct packed {
		logic active;
		logic eq_found;
		logic part_found;
		logic rm_found;
	} carry_t;

endpackage

FILE: design/kcpm_cell.sv
// one entry slot of the chord table with its share of the scan chain
// depends on kcpm_pkg
module kcpm_cell #(
	parameter int IDX   = 0,
	parameter int KEYS  = 4,
	parameter int PW    = 16,
	parameter int CNT_W = 5,
	parameter int LEN_W = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [kcpm_pkg::OP_W-1:0]    op,
	input  logic [kcpm_pkg::CODE_W-1:0]  q_codes [KEYS],
	input  logic [kcpm_pkg::MODS_W-1:0]  q_mods [KEYS],
	input  logic [LEN_W-1:0]             q_len,
	input  logic [PW-1:0]                q_pay,
	input  logic [CNT_W-1:0]             held,
	input  kcpm_pkg::carry_t             cin,
	input  logic [PW-1:0]                cin_pay,
	input  logic [kcpm_pkg::CODE_W-1:0]  nb_codes [KEYS],
	input  logic [kcpm_pkg::MODS_W-1:0]  nb_mods [KEYS],
	input  logic [PW-1:0]                nb_pay,
	output kcpm_pkg::carry_t             cout,
	output logic [PW-1:0]                cout_pay,
	output logic [kcpm_pkg::CODE_W-1:0]  e_codes [KEYS],
	output logic [kcpm_pkg::MODS_W-1:0]  e_mods [KEYS],
	output logic [PW-1:0]                e_pay
);
	import kcpm_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [CODE_W-1:0] codes_q [KEYS];
	logic [MODS_W-1:0] mods_q [KEYS];
	logic [PW-1:0]     pay_q;
	carry_t            carry_q;
	logic [PW-1:0]     carry_pay_q;

	logic             valid;
	logic [LEN_W-1:0] e_len;
	logic             pref_ok;
	logic             full_eq;
	logic             lk_match;
	logic             lk_eq;
	logic             rm_here;
	logic             shift;
	logic             load_new;

	always_comb begin
		valid   = MY_IDX < held;
		e_len   = LEN_W'(KEYS);
		pref_ok = 1'b1;
		full_eq = 1'b1;
		for (int j = KEYS - 1; j >= 0; j--) begin
			if (codes_q[j] == '0) begin
				e_len = LEN_W'(j);
			end
		end
		for (int j = 0; j < KEYS; j++) begin
			if (q_codes[j] != codes_q[j] || q_mods[j] != mods_q[j]) begin
				full_eq = 1'b0;
				if (LEN_W'(j) < q_len) begin
					pref_ok = 1'b0;
				end
			end
		end
		lk_match = valid && (op == OP_LOOKUP) && (q_len <= e_len) && pref_ok;
		lk_eq    = lk_match && (q_len == e_len);
		rm_here  = valid && (op == OP_REMOVE) && full_eq;
		// compaction: from the hit slot on, each later slot too pulls its younger neighbor
		shift    = cin.active && valid && (op == OP_REMOVE) && (cin.rm_found || full_eq);
		load_new = cin.active && (op == OP_ADD) && (MY_IDX == held);
	end

	always_ff @(posedge clk) begin
		if (load_new) begin
			codes_q <= q_codes;
			mods_q  <= q_mods;
			pay_q   <= q_pay;
		end else if (shift) begin
			codes_q <= nb_codes;
			mods_q  <= nb_mods;
			pay_q   <= nb_pay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q.active     <= cin.active;
			carry_q.eq_found   <= cin.eq_found | lk_eq;
			carry_q.part_found <= cin.part_found | (lk_match & ~lk_eq);
			carry_q.rm_found   <= cin.rm_found | rm_here;
		end
	end

	// oldest equal entry wins
	always_ff @(posedge clk) begin
		if (lk_eq && !cin.eq_found) begin
			carry_pay_q <= pay_q;
		end else begin
			carry_pay_q <= cin_pay;
		end
	end

	assign cout     = carry_q;
	assign cout_pay = carry_pay_q;
	assign e_codes  = codes_q;
	assign e_mods   = mods_q;
	assign e_pay    = pay_q;

endmodule

FILE: design/key_chord_prefix_match_table.sv
// top level of the key chord prefix match table: command port, query registers, cell row
// depends on kcpm_pkg and kcpm_cell
//
// The table holds up to TABLE_DEPTH key chords in the order they were added, one per cell,
// each with a payload word. Every item (lookup, add or remove) is taken when start is high
// and busy is low, and gives exactly one result, shown on status, payload_out and
// entry_count for the single cycle in which done is high; there is no way to hold a result
// off, so the receiver must take it in that cycle. A new item is taken only after the last
// one's walk: a scan token walks the row of cells one cell per cycle, each cell folding
// its own match into the token and, on remove, pulling its younger neighbor down from the
// deleted entry on. busy is high for the whole walk. There is no clearing pass after reset;
// only held entries are read.
module key_chord_prefix_match_table #(
	parameter int TABLE_DEPTH    = 16,
	parameter int KEYS_PER_CHORD = 4,
	parameter int PAYLOAD_WIDTH  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [kcpm_pkg::OP_W-1:0]          op,
	input  logic [kcpm_pkg::CODE_W-1:0]        key1_code,
	input  logic [kcpm_pkg::MODS_W-1:0]        key1_mods,
	input  logic [kcpm_pkg::CODE_W-1:0]        key2_code,
	input  logic [kcpm_pkg::MODS_W-1:0]        key2_mods,
	input  logic [kcpm_pkg::CODE_W-1:0]        key3_code,
	input  logic [kcpm_pkg::MODS_W-1:0]        key3_mods,
	input  logic [kcpm_pkg::CODE_W-1:0]        key4_code,
	input  logic [kcpm_pkg::MODS_W-1:0]        key4_mods,
	input  logic [kcpm_pkg::PAY_OUT_W-1:0]     payload_in,
	output logic                               done,
	output logic [kcpm_pkg::STATUS_W-1:0]      status,
	output logic [kcpm_pkg::PAY_OUT_W-1:0]     payload_out,
	output logic [kcpm_pkg::COUNT_W-1:0]       entry_count
);
	import kcpm_pkg::*;

	localparam int KEYS  = KEYS_PER_CHORD;
	localparam int PW    = PAYLOAD_WIDTH;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int LEN_W = $clog2(KEYS + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	// raw input pairs in chord order
	logic [CODE_W-1:0] in_codes [IN_PAIRS];
	logic [MODS_W-1:0] in_mods [IN_PAIRS];
	// chord padded or cut to KEYS pairs
	logic [CODE_W-1:0] nx_codes [KEYS];
	logic [MODS_W-1:0] nx_mods [KEYS];
	logic [LEN_W-1:0]  nx_len;

	// item registers, loaded at acceptance and held for the walk
	logic [OP_W-1:0]   op_q;
	logic [CODE_W-1:0] q_codes_q [KEYS];
	logic [MODS_W-1:0] q_mods_q [KEYS];
	logic [LEN_W-1:0]  q_len_q;
	logic [PW-1:0]     q_pay_q;

	// control
	logic              busy_q;
	logic              go_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;

	// result registers
	logic [STATUS_W-1:0]  status_q;
	logic [PAY_OUT_W-1:0] pay_out_q;

	// cell row wiring
	carry_t            carry [TABLE_DEPTH + 1];
	logic [PW-1:0]     carry_pay [TABLE_DEPTH + 1];
	logic [CODE_W-1:0] ent_codes [TABLE_DEPTH][KEYS];
	logic [MODS_W-1:0] ent_mods [TABLE_DEPTH][KEYS];
	logic [PW-1:0]     ent_pay [TABLE_DEPTH];

	logic     accept;
	carry_t   last;

	assign accept = start && !busy_q;

	assign in_codes[0] = key1_code;
	assign in_codes[1] = key2_code;
	assign in_codes[2] = key3_code;
	assign in_codes[3] = key4_code;
	assign in_mods[0]  = key1_mods;
	assign in_mods[1]  = key2_mods;
	assign in_mods[2]  = key3_mods;
	assign in_mods[3]  = key4_mods;

	// pairs past the fourth read as zero
	for (genvar g = 0; g < KEYS; g++) begin : g_pad
		if (g < IN_PAIRS) begin : g_in
			assign nx_codes[g] = in_codes[g];
			assign nx_mods[g]  = in_mods[g];
		end else begin : g_zero
			assign nx_codes[g] = '0;
			assign nx_mods[g]  = '0;
		end
	end

	// query length: number of leading nonzero codes
	always_comb begin
		nx_len = LEN_W'(KEYS);
		for (int j = KEYS - 1; j >= 0; j--) begin
			if (nx_codes[j] == '0) begin
				nx_len = LEN_W'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op;
			q_codes_q <= nx_codes;
			q_mods_q  <= nx_mods;
			q_len_q   <= nx_len;
			q_pay_q   <= PW'(payload_in);
		end
	end

	// token launched into the first cell the cycle after acceptance
	assign carry[0].active     = go_q;
	assign carry[0].eq_found   = 1'b0;
	assign carry[0].part_found = 1'b0;
	assign carry[0].rm_found   = 1'b0;
	assign carry_pay[0]        = '0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		if (g < TABLE_DEPTH - 1) begin : g_mid
			kcpm_cell #(
				.IDX(g), .KEYS(KEYS), .PW(PW), .CNT_W(CNT_W), .LEN_W(LEN_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.op       (op_q),
				.q_codes  (q_codes_q),
				.q_mods   (q_mods_q),
				.q_len    (q_len_q),
				.q_pay    (q_pay_q),
				.held     (cnt_q),
				.cin      (carry[g]),
				.cin_pay  (carry_pay[g]),
				.nb_codes (ent_codes[g+1]),
				.nb_mods  (ent_mods[g+1]),
				.nb_pay   (ent_pay[g+1]),
				.cout     (carry[g+1]),
				.cout_pay (carry_pay[g+1]),
				.e_codes  (ent_codes[g]),
				.e_mods   (ent_mods[g]),
				.e_pay    (ent_pay[g])
			);
		end else begin : g_end
			// the youngest slot has no neighbor; on a shift it keeps its own contents
			kcpm_cell #(
				.IDX(g), .KEYS(KEYS), .PW(PW), .CNT_W(CNT_W), .LEN_W(LEN_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.op       (op_q),
				.q_codes  (q_codes_q),
				.q_mods   (q_mods_q),
				.q_len    (q_len_q),
				.q_pay    (q_pay_q),
				.held     (cnt_q),
				.cin      (carry[g]),
				.cin_pay  (carry_pay[g]),
				.nb_codes (ent_codes[g]),
				.nb_mods  (ent_mods[g]),
				.nb_pay   (ent_pay[g]),
				.cout     (carry[g+1]),
				.cout_pay (carry_pay[g+1]),
				.e_codes  (ent_codes[g]),
				.e_mods   (ent_mods[g]),
				.e_pay    (ent_pay[g])
			);
		end
	end

	assign last = carry[TABLE_DEPTH];

	// control: busy from acceptance until the token leaves the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			go_q   <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			go_q   <= accept;
			done_q <= last.active;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.active) begin
				busy_q <= 1'b0;
			end
			if (last.active) begin
				if (op_q == OP_ADD && cnt_q != DEPTH_CNT) begin
					cnt_q <= cnt_q + 1'b1;
				end else if (op_q == OP_REMOVE && last.rm_found) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// result formed when the token comes out of the last cell
	always_ff @(posedge clk) begin
		if (last.active) begin
			// payload only for an equal lookup
			pay_out_q <= (op_q == OP_LOOKUP && last.eq_found) ?
				PAY_OUT_W'(carry_pay[TABLE_DEPTH]) : '0;
			unique case (op_q)
				OP_LOOKUP: begin
					if (last.eq_found) begin
						status_q <= ST_EQUAL;
					end else if (last.part_found) begin
						status_q <= ST_PARTIAL;
					end else begin
						status_q <= ST_NONE;
					end
				end
				OP_ADD: begin
					status_q <= (cnt_q == DEPTH_CNT) ? ST_FULL : ST_ADDED;
				end
				OP_REMOVE: begin
					status_q <= last.rm_found ? ST_REMOVED : ST_NOTFOUND;
				end
				default: begin
					status_q <= ST_NONE;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign status      = status_q;
	assign payload_out = pay_out_q;
	// count already updated by the time done is high
	assign entry_count = COUNT_W'(cnt_q);

endmodule

FILE: design/kcpm_checker.sv
// port-level checks for the key chord prefix match table, bound to the top level
// depends on kcpm_pkg and key_chord_prefix_match_table
module kcpm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [kcpm_pkg::STATUS_W-1:0]  status,
	input logic [kcpm_pkg::PAY_OUT_W-1:0] payload_out,
	input logic [kcpm_pkg::COUNT_W-1:0]   entry_count
);
	import kcpm_pkg::*;

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result only ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result strobe outside an item");

	// result strobe is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// payload only carried by an equal lookup
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_EQUAL |-> payload_out == '0)
		else $error("payload on a non-equal result");

	// an add that succeeded leaves at least one entry
	a_added_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_ADDED |-> entry_count != '0)
		else $error("added with empty table");

endmodule

bind key_chord_prefix_match_table kcpm_checker u_kcpm_checker (.*);

FILE: sim/kcpm_scoreboard.sv
// scoreboard of the key chord prefix match table: watches the command and result ports,
// predicts every result and compares it field by field
// depends on kcpm_pkg
module kcpm_scoreboard #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [kcpm_pkg::OP_W-1:0]      op,
	input  logic [kcpm_pkg::CODE_W-1:0]    key1_code,
	input  logic [kcpm_pkg::MODS_W-1:0]    key1_mods,
	input  logic [kcpm_pkg::CODE_W-1:0]    key2_code,
	input  logic [kcpm_pkg::MODS_W-1:0]    key2_mods,
	input  logic [kcpm_pkg::CODE_W-1:0]    key3_code,
	input  logic [kcpm_pkg::MODS_W-1:0]    key3_mods,
	input  logic [kcpm_pkg::CODE_W-1:0]    key4_code,
	input  logic [kcpm_pkg::MODS_W-1:0]    key4_mods,
	input  logic [kcpm_pkg::PAY_OUT_W-1:0] payload_in,
	input  logic                           done,
	input  logic [kcpm_pkg::STATUS_W-1:0]  status,
	input  logic [kcpm_pkg::PAY_OUT_W-1:0] payload_out,
	input  logic [kcpm_pkg::COUNT_W-1:0]   entry_count,
	output int                             mismatches,
	output int                             outstanding
);
	import kcpm_pkg::*;

	typedef struct packed {
		logic [IN_PAIRS-1:0][CODE_W-1:0] code;
		logic [IN_PAIRS-1:0][MODS_W-1:0] mods;
	} chord_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [PAY_OUT_W-1:0] payload;
		logic [COUNT_W-1:0]   count;
	} answer_t;

	chord_t               held_chord [TABLE_DEPTH];
	logic [PAY_OUT_W-1:0] held_pay [TABLE_DEPTH];
	int                   held_n = 0;
	int                   errs = 0;
	answer_t              awaited_answers [$];

	function automatic int chord_length(chord_t c);
		int n;
		n = 0;
		while (n < IN_PAIRS && c.code[n] != '0)
			n++;
		return n;
	endfunction

	// applies one command to the shadow table and returns the answer it gives
	function automatic answer_t apply_command(logic [OP_W-1:0] cmd, chord_t q,
			logic [PAY_OUT_W-1:0] pay);
		answer_t a;
		int      ql;
		int      el;
		logic    same;
		a = '0;
		a.status = ST_NONE;
		case (cmd)
			OP_LOOKUP: begin
				ql = chord_length(q);
				for (int k = 0; k < held_n; k++) begin
					el = chord_length(held_chord[k]);
					same = (ql <= el);
					for (int i = 0; i < ql; i++)
						if (q.code[i] != held_chord[k].code[i] ||
								q.mods[i] != held_chord[k].mods[i])
							same = 1'b0;
					if (same && ql == el) begin
						// oldest equal entry wins
						a.status = ST_EQUAL;
						a.payload = held_pay[k];
						break;
					end
					if (same)
						a.status = ST_PARTIAL;
				end
			end
			OP_ADD: begin
				if (held_n >= TABLE_DEPTH) begin
					a.status = ST_FULL;
				end else begin
					held_chord[held_n] = q;
					held_pay[held_n] = pay;
					held_n++;
					a.status = ST_ADDED;
				end
			end
			OP_REMOVE: begin
				a.status = ST_NOTFOUND;
				for (int k = 0; k < held_n; k++) begin
					// every pair counts here, also the ones past the terminator
					if (held_chord[k] == q) begin
						for (int j = k; j < held_n - 1; j++) begin
							held_chord[j] = held_chord[j + 1];
							held_pay[j] = held_pay[j + 1];
						end
						held_n--;
						a.status = ST_REMOVED;
						break;
					end
				end
			end
			default: a.status = ST_NONE;
		endcase
		a.count = held_n[COUNT_W-1:0];
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chord_t  q;
		answer_t want;
		if (!arst_n) begin
			held_n = 0;
			awaited_answers.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (start && !busy) begin
				q.code = {key4_code, key3_code, key2_code, key1_code};
				q.mods = {key4_mods, key3_mods, key2_mods, key1_mods};
				awaited_answers.push_back(apply_command(op, q, payload_in));
			end
			if (done) begin
				if (awaited_answers.size() == 0) begin
					$display("%0t unexpected result: status %0d payload %h count %0d",
						$time, status, payload_out, entry_count);
					errs++;
				end else begin
					want = awaited_answers.pop_front();
					if (status !== want.status) begin
						$display("%0t status: expected %0d actual %0d",
							$time, want.status, status);
						errs++;
					end
					if (payload_out !== want.payload) begin
						$display("%0t payload_out: expected %h actual %h",
							$time, want.payload, payload_out);
						errs++;
					end
					if (entry_count !== want.count) begin
						$display("%0t entry_count: expected %0d actual %0d",
							$time, want.count, entry_count);
						errs++;
					end
				end
			end
			mismatches <= errs;
			outstanding <= awaited_answers.size();
		end
	end

endmodule

FILE: sim/tb.sv
// testbench top of the key chord prefix match table: clock, reset, command stimulus, verdict
// depends on kcpm_pkg, key_chord_prefix_match_table and kcpm_scoreboard
module tb;
	import kcpm_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 900;
	localparam int CYCLE_LIMIT  = 400000;

	// the one op code that the block must ignore
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [IN_PAIRS-1:0][CODE_W-1:0] code;
		logic [IN_PAIRS-1:0][MODS_W-1:0] mods;
	} chord_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [OP_W-1:0]      op;
	logic [CODE_W-1:0]    key1_code, key2_code, key3_code, key4_code;
	logic [MODS_W-1:0]    key1_mods, key2_mods, key3_mods, key4_mods;
	logic [PAY_OUT_W-1:0] payload_in;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [PAY_OUT_W-1:0] payload_out;
	logic [COUNT_W-1:0]   entry_count;
	int                   mismatches;
	int                   outstanding;
	int                   cycles = 0;

	// chords that were added lately, so lookups and removes can hit real entries
	chord_t               added_chords [$];

	always #4 clk = ~clk;

	key_chord_prefix_match_table #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.key1_code(key1_code), .key1_mods(key1_mods),
		.key2_code(key2_code), .key2_mods(key2_mods),
		.key3_code(key3_code), .key3_mods(key3_mods),
		.key4_code(key4_code), .key4_mods(key4_mods),
		.payload_in(payload_in), .done(done), .status(status),
		.payload_out(payload_out), .entry_count(entry_count)
	);

	kcpm_scoreboard #(
		.TABLE_DEPTH(DEPTH)
	) score (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.key1_code(key1_code), .key1_mods(key1_mods),
		.key2_code(key2_code), .key2_mods(key2_mods),
		.key3_code(key3_code), .key3_mods(key3_mods),
		.key4_code(key4_code), .key4_mods(key4_mods),
		.payload_in(payload_in), .done(done), .status(status),
		.payload_out(payload_out), .entry_count(entry_count),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic chord_t make_chord(
			logic [CODE_W-1:0] c1, logic [MODS_W-1:0] m1,
			logic [CODE_W-1:0] c2, logic [MODS_W-1:0] m2,
			logic [CODE_W-1:0] c3, logic [MODS_W-1:0] m3,
			logic [CODE_W-1:0] c4, logic [MODS_W-1:0] m4);
		chord_t c;
		c.code = {c4, c3, c2, c1};
		c.mods = {m4, m3, m2, m1};
		return c;
	endfunction

	// mostly a small alphabet so chords collide and nest, now and then full width
	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(3) == 0)
			return CODE_W'($urandom());
		return CODE_W'($urandom_range(3, 1));
	endfunction

	function automatic logic [MODS_W-1:0] pick_mods();
		if ($urandom_range(1) == 0)
			return MODS_W'($urandom_range(1));
		return MODS_W'($urandom());
	endfunction

	// random chord; the pairs past the terminator sometimes carry junk
	function automatic chord_t fresh_chord();
		chord_t c;
		int     len;
		len = ($urandom_range(4) == 0) ? 0 : $urandom_range(IN_PAIRS, 1);
		for (int i = 0; i < IN_PAIRS; i++) begin
			if (i < len) begin
				c.code[i] = pick_code();
				c.mods[i] = pick_mods();
			end else begin
				c.code[i] = (i > len && $urandom_range(3) == 0) ? CODE_W'($urandom()) : '0;
				c.mods[i] = ($urandom_range(3) == 0) ? MODS_W'($urandom()) : '0;
			end
		end
		return c;
	endfunction

	function automatic chord_t pool_chord();
		if (added_chords.size() == 0)
			return fresh_chord();
		return added_chords[$urandom_range(added_chords.size() - 1)];
	endfunction

	// cut a chord short at a random place and sometimes scramble the masks from the cut on
	function automatic chord_t cut_chord(chord_t c);
		int j;
		j = $urandom_range(IN_PAIRS - 1);
		c.code[j] = '0;
		for (int i = j; i < IN_PAIRS; i++)
			if ($urandom_range(1) == 0)
				c.mods[i] = MODS_W'($urandom());
		return c;
	endfunction

	// flip one random bit of code or mask
	function automatic chord_t nudge_chord(chord_t c);
		int i;
		i = $urandom_range(IN_PAIRS - 1);
		if ($urandom_range(1) == 0)
			c.code[i][$urandom_range(CODE_W - 1)] ^= 1'b1;
		else
			c.mods[i][$urandom_range(MODS_W - 1)] ^= 1'b1;
		return c;
	endfunction

	// present one item and hold it until the block takes it; returns at that edge
	task automatic send_command(logic [OP_W-1:0] cmd, chord_t c,
			logic [PAY_OUT_W-1:0] pay, bit may_idle);
		int gap;
		gap = 0;
		if (may_idle && $urandom_range(99) < 29)
			gap = ($urandom_range(3) == 0) ? $urandom_range(24, 1) : $urandom_range(4, 1);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= cmd;
		key1_code <= c.code[0];
		key1_mods <= c.mods[0];
		key2_code <= c.code[1];
		key2_mods <= c.mods[1];
		key3_code <= c.code[2];
		key3_mods <= c.mods[2];
		key4_code <= c.code[3];
		key4_mods <= c.mods[3];
		payload_in <= pay;
		do @(posedge clk); while (busy);
		if (cmd == OP_ADD) begin
			added_chords.push_back(c);
			if (added_chords.size() > 48)
				void'(added_chords.pop_front());
		end
	endtask

	// stop sending until every result of the items in flight has come back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		chord_t                zero_chord;
		chord_t                max_chord;
		chord_t                chord_a;
		chord_t                chord_a_clean;
		chord_t                c;
		logic [OP_W-1:0]       cmd;
		int                    roll;
		bit                    filling;

		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_LOOKUP;
		key1_code <= '0;
		key1_mods <= '0;
		key2_code <= '0;
		key2_mods <= '0;
		key3_code <= '0;
		key3_mods <= '0;
		key4_code <= '0;
		key4_mods <= '0;
		payload_in <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		zero_chord = '0;
		max_chord = '1;
		// two keys, junk past the terminator that only remove looks at
		chord_a = make_chord(5, 1, 6, 2, 0, 7, 9, 3);
		chord_a_clean = make_chord(5, 1, 6, 2, 0, 0, 0, 0);

		// directed: empty table, extremes, duplicates, prefixes, remove rules
		send_command(OP_LOOKUP, max_chord, 16'h0000, 1'b0);
		send_command(OP_REMOVE, zero_chord, 16'h0000, 1'b0);
		send_command(OP_ADD, zero_chord, 16'hFFFF, 1'b0);
		send_command(OP_ADD, max_chord, 16'h0000, 1'b0);
		send_command(OP_ADD, chord_a, 16'h1111, 1'b0);
		send_command(OP_ADD, chord_a, 16'h2222, 1'b0);
		send_command(OP_ADD, make_chord(5, 1, 6, 2, 7, 0, 8, 4), 16'h3333, 1'b0);
		// empty query matches all, the empty entry is equal
		send_command(OP_LOOKUP, zero_chord, 16'h0000, 1'b0);
		send_command(OP_LOOKUP, make_chord(5, 1, 0, 0, 0, 0, 0, 0), 16'h0000, 1'b0);
		// lookup ignores pairs past the terminator, oldest equal wins
		send_command(OP_LOOKUP, chord_a_clean, 16'h0000, 1'b0);
		send_command(OP_LOOKUP, make_chord(5, 2, 0, 0, 0, 0, 0, 0), 16'h0000, 1'b0);
		send_command(OP_LOOKUP, max_chord, 16'h0000, 1'b0);
		// remove does not ignore them
		send_command(OP_REMOVE, chord_a_clean, 16'h0000, 1'b0);
		send_command(OP_REMOVE, chord_a, 16'h0000, 1'b0);
		send_command(OP_LOOKUP, chord_a, 16'h0000, 1'b0);
		send_command(OP_SPARE, max_chord, 16'hFFFF, 1'b0);
		send_command(OP_REMOVE, zero_chord, 16'h0000, 1'b0);
		send_command(OP_LOOKUP, zero_chord, 16'h0000, 1'b0);
		send_command(OP_REMOVE, max_chord, 16'h0000, 1'b0);
		send_command(OP_LOOKUP, max_chord, 16'h0000, 1'b0);
		drain_results();

		// random: fill and drain phases take turns so the table runs full and empty
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			filling = ((n / 120) % 2) == 0;
			roll = $urandom_range(99);
			if (roll < 4)
				cmd = OP_SPARE;
			else if (roll < (filling ? 60 : 28))
				cmd = OP_ADD;
			else if (roll < (filling ? 75 : 62))
				cmd = OP_REMOVE;
			else
				cmd = OP_LOOKUP;

			roll = $urandom_range(99);
			case (cmd)
				OP_ADD: begin
					// duplicates and one-bit variants of held chords as well as new ones
					if (roll < 15)
						c = pool_chord();
					else if (roll < 35)
						c = nudge_chord(pool_chord());
					else
						c = fresh_chord();
				end
				OP_REMOVE: begin
					if (roll < 70)
						c = pool_chord();
					else if (roll < 85)
						c = nudge_chord(pool_chord());
					else
						c = fresh_chord();
				end
				OP_LOOKUP: begin
					if (roll < 35)
						c = pool_chord();
					else if (roll < 70)
						c = cut_chord(pool_chord());
					else if (roll < 85)
						c = nudge_chord(pool_chord());
					else
						c = fresh_chord();
				end
				default: c = fresh_chord();
			endcase

			if (n == 450)
				drain_results();
			// a long run of back to back items in the middle
			send_command(cmd, c, PAY_OUT_W'($urandom()), !(n >= 500 && n < 650));
		end

		drain_results();
		repeat (2 * DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
